[src/hcbp_pkg.sv]
`timescale 1ns / 1ps
package hcbp_pkg;

    localparam int SYMBOL_COUNT_DEF = 256;
    localparam int MAX_CODE_LEN_DEF = 32;

    typedef logic [1:0] t_func;
    localparam t_func FUNC_LOAD  = 2'd0;
    localparam t_func FUNC_ENC   = 2'd1;
    localparam t_func FUNC_FLUSH = 2'd2;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_DATA  = 2'd0;
    localparam t_kind KIND_FINAL = 2'd1;
    localparam t_kind KIND_END   = 2'd2;
    localparam t_kind KIND_ERR   = 2'd3;

endpackage

[src/huffman_code_table_bit_packer_core.sv]
`timescale 1ns / 1ps
// channel   dir  tdata (low bit up)                          tuser   tlast
// s_axis    in   symbol 8, code_word 32, code_size 6, pad 2   func    -
// m_axis    out  out_byte 8, pad_count 3, pad 5               kind    last
//
// an encode request reads its table entry (registered ram read), then the packer emits
// one completed byte per cycle, unless the output stalls, from a 40-bit left-aligned
// accumulator. a request waits in the read stage until the packer holds under a byte;
// the next encode merges in the cycle of the previous one's last byte. a flush or a
// missing code is answered into the output register as it leaves the read stage.
// loads write the table at acceptance and give no result.
// reset (synchronous) clears the per-entry valid bits, accumulator and both stages.
// a stalled output holds its byte; the packer and then the read stage back up behind it.
module huffman_code_table_bit_packer_core import hcbp_pkg::*; #(
    parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // symbol, code_word, code_size, zero pad
    input  logic [1:0]  s_axis_tuser,   // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_byte, pad_count, zero pad
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast
);

    localparam int LEN_CAP = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
    localparam int LEN_W   = $clog2(LEN_CAP + 1);
    localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
    localparam int ENT_W   = LEN_W + LEN_CAP;
    localparam int BUF_W   = LEN_CAP + 8;
    localparam int CNT_W   = $clog2(BUF_W);

    t_func             in_func;
    logic [7:0]        in_symbol;
    logic [31:0]       in_code_word;
    logic [5:0]        in_code_size;
    logic              accept;
    logic              sym_ok;
    logic [LEN_W-1:0]  size_sat;
    logic              ram_we;
    logic              ram_re;
    logic [ENT_W-1:0]  ram_rdata;

    logic [SYMBOL_COUNT-1:0] r_valid;
    logic              r_a_valid;
    t_func             r_a_func;
    logic              r_a_ok;

    logic [BUF_W-1:0]  r_buf;
    logic [CNT_W-1:0]  r_cnt;
    logic [BUF_W-1:0]  n_buf;
    logic [CNT_W-1:0]  n_cnt;

    logic              r_o_valid;
    logic [7:0]        r_o_byte;
    t_kind             r_o_kind;
    logic [2:0]        r_o_pad;
    logic              r_o_last;

    logic [LEN_W-1:0]  a_len;
    logic [LEN_CAP-1:0] a_code;
    logic [LEN_CAP-1:0] code_left;
    logic [BUF_W-1:0]  code_buf;
    logic              a_is_enc;
    logic              a_bad;
    logic              a_take;
    logic              out_free;
    logic              emit;
    logic [BUF_W-1:0]  buf_after;
    logic [CNT_W-1:0]  cnt_after;
    logic              pend_only;

    assign in_func      = s_axis_tuser;
    assign in_symbol    = s_axis_tdata[7:0];
    assign in_code_word = s_axis_tdata[39:8];
    assign in_code_size = s_axis_tdata[45:40];

    assign accept = s_axis_tvalid && s_axis_tready;
    assign sym_ok = {1'b0, in_symbol} < 9'(SYMBOL_COUNT);

    always_comb begin
        if (in_code_size > 6'(LEN_CAP)) begin
            size_sat = LEN_W'(LEN_CAP);
        end else begin
            size_sat = LEN_W'(in_code_size);
        end
    end

    assign ram_we = accept && (in_func == FUNC_LOAD) && sym_ok;
    assign ram_re = accept && (in_func == FUNC_ENC);

    hcbp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (in_symbol[ADDR_W-1:0]),
        .i_wdata ({size_sat, in_code_word[LEN_CAP-1:0]}),
        .i_re    (ram_re),
        .i_raddr (in_symbol[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // read stage
    assign a_len    = r_a_ok ? ram_rdata[ENT_W-1 -: LEN_W] : '0;
    assign a_code   = ram_rdata[LEN_CAP-1:0];
    assign a_is_enc = (r_a_func == FUNC_ENC);
    assign a_bad    = a_is_enc && (a_len == '0);

    // packer
    assign out_free  = !r_o_valid || m_axis_tready;
    assign emit      = out_free && (r_cnt[CNT_W-1:3] != '0);
    assign buf_after = emit ? (r_buf << 8) : r_buf;
    assign cnt_after = emit ? (r_cnt - CNT_W'(8)) : r_cnt;
    assign pend_only = (cnt_after[CNT_W-1:3] == '0);

    assign code_left = a_code << (LEN_W'(LEN_CAP) - a_len);
    assign code_buf  = {code_left, 8'h00} >> cnt_after;

    always_comb begin
        if (!r_a_valid) begin
            a_take = 1'b0;
        end else if (a_is_enc && !a_bad) begin
            a_take = pend_only;
        end else begin
            a_take = out_free && (r_cnt[CNT_W-1:3] == '0);
        end
    end

    assign s_axis_tready = !r_a_valid || a_take;

    always_comb begin
        n_buf = buf_after;
        n_cnt = cnt_after;
        if (a_take) begin
            if (a_is_enc && !a_bad) begin
                n_buf = buf_after | code_buf;
                n_cnt = cnt_after + CNT_W'(a_len);
            end else begin
                n_buf = '0;
                n_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_a_valid <= 1'b0;
            r_buf     <= '0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (ram_we) begin
                r_valid[in_symbol[ADDR_W-1:0]] <= 1'b1;
            end
            if (accept && (in_func == FUNC_ENC || in_func == FUNC_FLUSH)) begin
                r_a_valid <= 1'b1;
            end else if (a_take) begin
                r_a_valid <= 1'b0;
            end
            r_buf <= n_buf;
            r_cnt <= n_cnt;
            if (emit || (a_take && !(a_is_enc && !a_bad))) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (in_func == FUNC_ENC || in_func == FUNC_FLUSH)) begin
            r_a_func <= in_func;
            r_a_ok   <= sym_ok && r_valid[in_symbol[ADDR_W-1:0]];
        end
        if (emit) begin
            r_o_byte <= r_buf[BUF_W-1 -: 8];
            r_o_kind <= KIND_DATA;
            r_o_pad  <= 3'd0;
            r_o_last <= (r_cnt[CNT_W-1:3] == (CNT_W-3)'(1));
        end else if (a_take && a_bad) begin
            r_o_byte <= 8'h00;
            r_o_kind <= KIND_ERR;
            r_o_pad  <= 3'd0;
            r_o_last <= 1'b1;
        end else if (a_take && !a_is_enc) begin
            r_o_last <= 1'b1;
            if (r_cnt == '0) begin
                r_o_byte <= 8'h00;
                r_o_kind <= KIND_END;
                r_o_pad  <= 3'd0;
            end else begin
                r_o_byte <= r_buf[BUF_W-1 -: 8];
                r_o_kind <= KIND_FINAL;
                r_o_pad  <= 3'(4'd8 - {1'b0, r_cnt[2:0]});
            end
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {5'b0, r_o_pad, r_o_byte};
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tlast  = r_o_last;

endmodule

[src/hcbp_ram.sv]
`timescale 1ns / 1ps
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/hcbp_checker.sv]
`timescale 1ns / 1ps
module hcbp_checker import hcbp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

    // no result right after reset
    assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
    else $error("result valid after reset");

    // end and error results are single, empty and last
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_END || m_axis_tuser == KIND_ERR)
            |-> m_axis_tlast && (m_axis_tdata == 16'h0000))
    else $error("bad end or error result");

    // final byte pads between one and seven bits and closes the request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_FINAL)
            |-> m_axis_tlast && (m_axis_tdata[10:8] != 3'd0))
    else $error("bad final byte");

    // data bytes carry no padding
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_DATA) |-> (m_axis_tdata[15:8] == 8'h00))
    else $error("data byte with padding");

endmodule

bind huffman_code_table_bit_packer_core hcbp_checker u_hcbp_checker (.*);
